// File: rtl/core/block_request_tracker_macros.svh
// assertion macros for the block request tracker
`ifndef BLOCK_REQUEST_TRACKER_MACROS_SVH
`define BLOCK_REQUEST_TRACKER_MACROS_SVH
`ifndef SYNTH
`define BRT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BRT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BRT_ASSERT_IMPL(label, ante, cons)
`define BRT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/core/brt_pkg.sv
// shared types and constants of the block request tracker
`default_nettype none
package brt_pkg;
  localparam int MAX_PIECES  = 1024;
  localparam int MAX_BLOCKS  = 64;
  localparam int BLOCK_SHIFT = 14;
  localparam int BLOCK_BYTES = 1 << BLOCK_SHIFT;

  localparam logic [2:0] OP_REQUEST = 3'd0;
  localparam logic [2:0] OP_WRITING = 3'd1;
  localparam logic [2:0] OP_FINISH  = 3'd2;
  localparam logic [2:0] OP_ABORT   = 3'd3;
  localparam logic [2:0] OP_CANCEL  = 3'd4;
  localparam logic [2:0] OP_RESTORE = 3'd5;
  localparam logic [2:0] OP_HAVE    = 3'd6;

  localparam logic [1:0] BS_NONE  = 2'd0;
  localparam logic [1:0] BS_REQ   = 2'd1;
  localparam logic [1:0] BS_WRITE = 2'd2;
  localparam logic [1:0] BS_DONE  = 2'd3;

  localparam logic [1:0] REG_PIECE_COUNT   = 2'd0;
  localparam logic [1:0] REG_PIECE_BYTES   = 2'd1;
  localparam logic [1:0] REG_CONTENT_BYTES = 2'd2;

  typedef struct packed {
    logic [2:0] opcode;
    logic [9:0] piece_index;
    logic [5:0] block_index;
    logic [3:0] peer_id;
  } cmd_t;

  typedef struct packed {
    logic       status;
    logic [1:0] block_status;
    logic       piece_complete;
    logic [6:0] requested_blocks;
    logic [6:0] writing_blocks;
    logic [6:0] finished_blocks;
  } res_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RD1, S_RD2, S_EXEC, S_ACT, S_CQ, S_CN, S_CB, S_CW
  } state_t;
endpackage
`default_nettype wire

// File: rtl/core/brt_geom.sv
// block count of a piece: registered multiply, then tail clamp and ceiling shift
`default_nettype none
module brt_geom (
  input  wire logic        clk,
  input  wire logic [9:0]  piece,
  input  wire logic [10:0] piece_count,
  input  wire logic [20:0] piece_bytes,
  input  wire logic [30:0] content_bytes,
  output logic      [6:0]  nb
);
  logic [30:0]        prod;
  logic               last;
  logic signed [32:0] tail;
  logic [20:0]        size;
  logic [21:0]        sum;
  logic [7:0]         nb_raw;
  logic [6:0]         nb_next;

  always_ff @(posedge clk) begin
    prod <= 31'({21'd0, piece} * {10'd0, piece_bytes});
    last <= ({1'b0, piece} + 11'd1) >= piece_count;
    nb   <= nb_next;
  end

  always_comb begin
    tail = $signed({2'b00, content_bytes}) - $signed({2'b00, prod});
    if (!last || tail > $signed({12'd0, piece_bytes})) begin
      size = piece_bytes;
    end else begin
      size = tail[20:0];
    end
    sum    = {1'b0, size} + 22'(brt_pkg::BLOCK_BYTES - 1);
    nb_raw = sum[21:brt_pkg::BLOCK_SHIFT];
    if (last && tail <= 33'sd0) begin
      nb_next = 7'd0;
    end else if (nb_raw > 8'(brt_pkg::MAX_BLOCKS)) begin
      nb_next = 7'(brt_pkg::MAX_BLOCKS);
    end else begin
      nb_next = nb_raw[6:0];
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/block_request_tracker.sv
// top level: sequencer, piece flag, tally and block memories
// A command keeps busy high while it runs: a per-block command steps through
// flag read, block count, table read and update, and when it activates a piece
// it first clears every block of that piece in the block memory, one by one. A
// piece index out of range is answered in the next cycle without raising busy.
// Cancel peer visits all 1024 pieces: a piece that is inactive or has no blocks
// gets a flag and tally read and a check, an active one also a read and a write
// per block, one block memory port doing the work. After reset and after any
// register write a pass over all 1024 piece flags clears them while busy
// stays high. The result is shown for one cycle with done high and cannot
// be held off, so it must be taken when it appears.
`default_nettype none
`include "block_request_tracker_macros.svh"
module block_request_tracker (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire brt_pkg::cmd_t cmd,
  output logic               busy,
  output logic               done,
  output brt_pkg::res_t      result,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [30:0]   cfg_data
);
  logic [1:0]  flag_mem  [0:1023];
  logic [20:0] tally_mem [0:1023];
  logic [17:0] blk_mem   [0:65535];

  brt_pkg::state_t state, state_next;
  brt_pkg::cmd_t   item;
  brt_pkg::res_t   res_next;
  logic [10:0] piece_count;
  logic [20:0] piece_bytes;
  logic [30:0] content_bytes;
  logic [9:0]  cnt, cnt_next;
  logic [5:0]  j, j_next;
  logic        fresh, fresh_next;
  logic [6:0]  t_req, t_wr, t_fin, t_req_next;
  logic        done_next;
  logic [1:0]  flag_q;
  logic [20:0] tally_q;
  logic [17:0] blk_q;
  logic [6:0]  nb;
  logic [9:0]  geo_piece;

  logic        flag_re, flag_we, tally_re, tally_we, blk_re, blk_we;
  logic [9:0]  flag_addr, tally_addr;
  logic [15:0] blk_addr;
  logic [1:0]  flag_wd;
  logic [20:0] tally_wd;
  logic [17:0] blk_wd;

  logic        owned, act;
  logic [1:0]  prog0, prog1;
  logic [15:0] peers0, peers1, pbit;
  logic [6:0]  req0, wr0, fin0, req1, wr1, fin1;
  logic        cfg_hit;

  assign busy = (state != brt_pkg::S_IDLE);
  assign geo_piece = (item.opcode == brt_pkg::OP_CANCEL) ? cnt : item.piece_index;
  assign pbit = 16'd1 << item.peer_id;
  assign cfg_hit = cfg_we && (cfg_index == brt_pkg::REG_PIECE_COUNT ||
                              cfg_index == brt_pkg::REG_PIECE_BYTES ||
                              cfg_index == brt_pkg::REG_CONTENT_BYTES);

  brt_geom u_geom (
    .clk(clk), .piece(geo_piece), .piece_count(piece_count),
    .piece_bytes(piece_bytes), .content_bytes(content_bytes), .nb(nb)
  );

  always_ff @(posedge clk) begin
    if (flag_we) flag_mem[flag_addr] <= flag_wd;
    if (flag_re) flag_q <= flag_mem[flag_addr];
    if (tally_we) tally_mem[tally_addr] <= tally_wd;
    if (tally_re) tally_q <= tally_mem[tally_addr];
    if (blk_we) blk_mem[blk_addr] <= blk_wd;
    if (blk_re) blk_q <= blk_mem[blk_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      piece_count   <= 11'd1024;
      piece_bytes   <= 21'd1048576;
      content_bytes <= 31'd1073741824;
    end else if (cfg_we) begin
      unique case (cfg_index)
        brt_pkg::REG_PIECE_COUNT:   piece_count   <= cfg_data[10:0];
        brt_pkg::REG_PIECE_BYTES:   piece_bytes   <= cfg_data[20:0];
        brt_pkg::REG_CONTENT_BYTES: content_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= brt_pkg::S_CLR;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      done  <= done_next;
    end
    if (start && !busy) item <= cmd;
    j      <= j_next;
    fresh  <= fresh_next;
    t_req  <= t_req_next;
    result <= res_next;
    if (state == brt_pkg::S_CN) begin
      t_wr  <= tally_q[13:7];
      t_fin <= tally_q[6:0];
    end
  end

  // effective block and piece values, zero right after activation, and their updates per opcode
  always_comb begin
    owned  = flag_q[1];
    act    = flag_q[0] | fresh;
    prog0  = fresh ? brt_pkg::BS_NONE : blk_q[17:16];
    peers0 = fresh ? 16'd0 : blk_q[15:0];
    req0   = fresh ? 7'd0 : tally_q[20:14];
    wr0    = fresh ? 7'd0 : tally_q[13:7];
    fin0   = fresh ? 7'd0 : tally_q[6:0];
    prog1  = prog0;
    peers1 = peers0;
    req1   = req0;
    wr1    = wr0;
    fin1   = fin0;
    unique case (item.opcode)
      brt_pkg::OP_REQUEST: begin
        if (prog0 == brt_pkg::BS_NONE) begin
          prog1 = brt_pkg::BS_REQ;
          req1  = req0 + 7'd1;
        end
        peers1 = peers0 | pbit;
      end
      brt_pkg::OP_WRITING: begin
        if (act && prog0 == brt_pkg::BS_REQ) begin
          prog1 = brt_pkg::BS_WRITE;
          req1  = req0 - 7'd1;
          wr1   = wr0 + 7'd1;
        end
      end
      brt_pkg::OP_FINISH: begin
        if (prog0 == brt_pkg::BS_REQ) req1 = req0 - 7'd1;
        else if (prog0 == brt_pkg::BS_WRITE) wr1 = wr0 - 7'd1;
        if (prog0 != brt_pkg::BS_DONE) begin
          prog1 = brt_pkg::BS_DONE;
          fin1  = fin0 + 7'd1;
        end
        peers1 = 16'd0;
      end
      brt_pkg::OP_ABORT: begin
        if (act) begin
          peers1 = peers0 & ~pbit;
          if (prog0 == brt_pkg::BS_REQ && peers1 == 16'd0) begin
            prog1 = brt_pkg::BS_NONE;
            req1  = req0 - 7'd1;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    j_next     = j;
    fresh_next = fresh;
    t_req_next = t_req;
    done_next  = 1'b0;
    res_next   = result;
    flag_re = 1'b0; flag_we = 1'b0; flag_addr = item.piece_index; flag_wd = 2'b00;
    tally_re = 1'b0; tally_we = 1'b0; tally_addr = item.piece_index;
    tally_wd = {req1, wr1, fin1};
    blk_re = 1'b0; blk_we = 1'b0; blk_addr = {item.piece_index, item.block_index};
    blk_wd = {prog1, peers1};
    unique case (state)
      brt_pkg::S_CLR: begin
        flag_we   = 1'b1;
        flag_addr = cnt;
        cnt_next  = cnt + 10'd1;
        if (cnt == 10'(brt_pkg::MAX_PIECES - 1)) state_next = brt_pkg::S_IDLE;
      end
      brt_pkg::S_IDLE: begin
        if (start) begin
          fresh_next = 1'b0;
          j_next     = '0;
          if (cmd.opcode == brt_pkg::OP_CANCEL) begin
            cnt_next   = '0;
            state_next = brt_pkg::S_CQ;
          end else if ({1'b0, cmd.piece_index} >= piece_count) begin
            res_next        = '0;
            res_next.status = 1'b1;
            done_next       = 1'b1;
          end else begin
            state_next = brt_pkg::S_RD1;
          end
        end
      end
      brt_pkg::S_RD1: begin
        flag_re    = 1'b1;
        state_next = brt_pkg::S_RD2;
      end
      brt_pkg::S_RD2: begin
        tally_re   = 1'b1;
        blk_re     = 1'b1;
        state_next = brt_pkg::S_EXEC;
      end
      brt_pkg::S_EXEC: begin
        res_next = '0;
        if (item.opcode == brt_pkg::OP_RESTORE || item.opcode == brt_pkg::OP_HAVE) begin
          flag_we = 1'b1;
          flag_wd = {owned | (item.opcode == brt_pkg::OP_HAVE), 1'b0};
          res_next.block_status = flag_wd[1] ? brt_pkg::BS_DONE : brt_pkg::BS_NONE;
          done_next  = 1'b1;
          state_next = brt_pkg::S_IDLE;
        end else if ({1'b0, item.block_index} >= nb) begin
          res_next.status = 1'b1;
          done_next  = 1'b1;
          state_next = brt_pkg::S_IDLE;
        end else if (!act && (item.opcode == brt_pkg::OP_REQUEST ||
                              item.opcode == brt_pkg::OP_FINISH)) begin
          j_next     = '0;
          state_next = brt_pkg::S_ACT;
        end else begin
          if (act) begin
            blk_we   = 1'b1;
            tally_we = 1'b1;
            res_next.requested_blocks = req1;
            res_next.writing_blocks   = wr1;
            res_next.finished_blocks  = fin1;
          end
          if (fresh) begin
            flag_we = 1'b1;
            flag_wd = {owned, 1'b1};
          end
          res_next.block_status = owned ? brt_pkg::BS_DONE :
                                  (act ? prog1 : brt_pkg::BS_NONE);
          res_next.piece_complete = (item.opcode == brt_pkg::OP_FINISH) && (fin1 == nb);
          done_next  = 1'b1;
          state_next = brt_pkg::S_IDLE;
        end
      end
      brt_pkg::S_ACT: begin
        blk_we   = 1'b1;
        blk_addr = {item.piece_index, j};
        blk_wd   = '0;
        j_next   = j + 6'd1;
        if (j == 6'(brt_pkg::MAX_BLOCKS - 1)) begin
          fresh_next = 1'b1;
          state_next = brt_pkg::S_EXEC;
        end
      end
      brt_pkg::S_CQ: begin
        flag_re    = 1'b1;
        flag_addr  = cnt;
        tally_re   = 1'b1;
        tally_addr = cnt;
        j_next     = '0;
        state_next = brt_pkg::S_CN;
      end
      brt_pkg::S_CN: begin
        t_req_next = tally_q[20:14];
        state_next = brt_pkg::S_CB;
      end
      brt_pkg::S_CB: begin
        if (!flag_q[0] || nb == 7'd0) begin
          if (cnt == 10'(brt_pkg::MAX_PIECES - 1)) begin
            res_next   = '0;
            done_next  = 1'b1;
            state_next = brt_pkg::S_IDLE;
          end else begin
            cnt_next   = cnt + 10'd1;
            state_next = brt_pkg::S_CQ;
          end
        end else begin
          blk_re     = 1'b1;
          blk_addr   = {cnt, j};
          state_next = brt_pkg::S_CW;
        end
      end
      brt_pkg::S_CW: begin
        blk_we     = 1'b1;
        blk_addr   = {cnt, j};
        blk_wd     = {blk_q[17:16], blk_q[15:0] & ~pbit};
        if (blk_q[17:16] == brt_pkg::BS_REQ && (blk_q[15:0] & ~pbit) == 16'd0) begin
          blk_wd[17:16] = brt_pkg::BS_NONE;
          t_req_next    = t_req - 7'd1;
        end
        tally_we   = 1'b1;
        tally_addr = cnt;
        tally_wd   = {t_req_next, t_wr, t_fin};
        if (({1'b0, j} + 7'd1) == nb) begin
          if (cnt == 10'(brt_pkg::MAX_PIECES - 1)) begin
            res_next   = '0;
            done_next  = 1'b1;
            state_next = brt_pkg::S_IDLE;
          end else begin
            cnt_next   = cnt + 10'd1;
            state_next = brt_pkg::S_CQ;
          end
        end else begin
          j_next     = j + 6'd1;
          state_next = brt_pkg::S_CB;
        end
      end
      default: state_next = brt_pkg::S_IDLE;
    endcase
    // a register write restarts the flag clearing pass
    if (cfg_hit) begin
      state_next = brt_pkg::S_CLR;
      cnt_next   = '0;
    end
  end

  // an accepted transaction either goes busy or, with a bad piece index, answers at once
  `BRT_ASSERT_IMPL(a_done_not_busy, done, !busy)
  `BRT_ASSERT_NEXT(a_accept_busy, start && !busy && !cfg_hit, busy != done)
  `BRT_ASSERT_IMPL(a_error_clean, done && result.status,
                   result.block_status == 2'd0 && !result.piece_complete &&
                   result.requested_blocks == 7'd0 && result.finished_blocks == 7'd0)
endmodule
`default_nettype wire

// File: verif/brt_checker.sv
// checker for the block request tracker: predicts each result and compares it
module brt_checker
  import brt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  cmd_t        cmd,
  input  logic        done,
  input  res_t        result,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          checked
);
  longint      piece_total;
  longint      piece_len;
  longint      content_len;
  bit          owned [MAX_PIECES];
  bit          active [MAX_PIECES];
  logic [1:0]  progress [MAX_PIECES][MAX_BLOCKS];
  logic [15:0] peer_set [MAX_PIECES][MAX_BLOCKS];
  logic [6:0]  req_tally [MAX_PIECES];
  logic [6:0]  wr_tally [MAX_PIECES];
  logic [6:0]  fin_tally [MAX_PIECES];
  res_t        expected_results [$];
  int          mismatches;

  function automatic int piece_block_count(int p);
    longint sz;
    longint tail;
    longint nb;
    if (p + 1 < piece_total) begin
      sz = piece_len;
    end else begin
      tail = content_len - longint'(p) * piece_len;
      if (tail <= 0) return 0;
      sz = (tail < piece_len) ? tail : piece_len;
    end
    nb = (sz + BLOCK_BYTES - 1) / BLOCK_BYTES;
    if (nb > MAX_BLOCKS) nb = MAX_BLOCKS;
    return int'(nb);
  endfunction

  function automatic void activate_piece(int p);
    if (active[p]) return;
    active[p] = 1'b1;
    for (int j = 0; j < MAX_BLOCKS; j++) begin
      progress[p][j] = BS_NONE;
      peer_set[p][j] = '0;
    end
    req_tally[p] = '0;
    wr_tally[p] = '0;
    fin_tally[p] = '0;
  endfunction

  function automatic void drop_peer(int p, int b, logic [15:0] mask);
    peer_set[p][b] &= ~mask;
    if (progress[p][b] == BS_REQ && peer_set[p][b] == '0) begin
      progress[p][b] = BS_NONE;
      req_tally[p]--;
    end
  endfunction

  function automatic res_t track_command(cmd_t c);
    res_t        r;
    int          nb;
    int          p;
    int          b;
    logic [15:0] mask;
    r = '0;
    mask = 16'(1) << c.peer_id;
    if (c.opcode == OP_CANCEL) begin
      for (int q = 0; q < MAX_PIECES; q++) begin
        if (active[q]) begin
          nb = piece_block_count(q);
          for (int j = 0; j < nb; j++) drop_peer(q, j, mask);
        end
      end
      return r;
    end
    if (longint'(c.piece_index) >= piece_total) begin
      r.status = 1'b1;
      return r;
    end
    p = c.piece_index;
    if (c.opcode == OP_RESTORE || c.opcode == OP_HAVE) begin
      if (c.opcode == OP_HAVE) owned[p] = 1'b1;
      active[p] = 1'b0;
      r.block_status = owned[p] ? BS_DONE : BS_NONE;
      return r;
    end
    nb = piece_block_count(p);
    if (c.block_index >= nb) begin
      r.status = 1'b1;
      return r;
    end
    b = c.block_index;
    case (c.opcode)
      OP_REQUEST: begin
        activate_piece(p);
        if (progress[p][b] == BS_NONE) begin
          progress[p][b] = BS_REQ;
          req_tally[p]++;
        end
        peer_set[p][b] |= mask;
      end
      OP_WRITING: begin
        if (active[p] && progress[p][b] == BS_REQ) begin
          progress[p][b] = BS_WRITE;
          req_tally[p]--;
          wr_tally[p]++;
        end
      end
      OP_FINISH: begin
        activate_piece(p);
        if (progress[p][b] == BS_REQ) req_tally[p]--;
        else if (progress[p][b] == BS_WRITE) wr_tally[p]--;
        if (progress[p][b] != BS_DONE) begin
          progress[p][b] = BS_DONE;
          fin_tally[p]++;
        end
        peer_set[p][b] = '0;
        r.piece_complete = (fin_tally[p] == nb);
      end
      OP_ABORT: begin
        if (active[p]) drop_peer(p, b, mask);
      end
      default: ;
    endcase
    if (owned[p]) r.block_status = BS_DONE;
    else if (active[p]) r.block_status = progress[p][b];
    if (active[p]) begin
      r.requested_blocks = req_tally[p];
      r.writing_blocks = wr_tally[p];
      r.finished_blocks = fin_tally[p];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      piece_total = MAX_PIECES;
      piece_len = 1048576;
      content_len = 1073741824;
      for (int q = 0; q < MAX_PIECES; q++) begin
        owned[q] = 1'b0;
        active[q] = 1'b0;
      end
      expected_results.delete();
      mismatches = 0;
      fail_count <= 0;
      checked <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PIECE_COUNT:   piece_total = cfg_data[10:0];
          REG_PIECE_BYTES:   piece_len = cfg_data[20:0];
          REG_CONTENT_BYTES: content_len = cfg_data;
          default: ;
        endcase
        if (cfg_index == REG_PIECE_COUNT || cfg_index == REG_PIECE_BYTES ||
            cfg_index == REG_CONTENT_BYTES) begin
          for (int q = 0; q < MAX_PIECES; q++) begin
            owned[q] = 1'b0;
            active[q] = 1'b0;
          end
        end
      end
      if (start && !busy) expected_results = {expected_results, track_command(cmd)};
      if (done) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", result);
        end else begin
          want = expected_results.pop_front();
          checked <= checked + 1;
          if (result.status !== want.status
              || result.block_status !== want.block_status
              || result.piece_complete !== want.piece_complete
              || result.requested_blocks !== want.requested_blocks
              || result.writing_blocks !== want.writing_blocks
              || result.finished_blocks !== want.finished_blocks) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, result);
          end
        end
      end
      fail_count <= mismatches;
    end
    pending <= expected_results.size();
  end
endmodule

// File: verif/tb_top.sv
// testbench top for the block request tracker: stimulus, phases and verdict
module tb_top;
  import brt_pkg::*;

  localparam logic [2:0] OP_QUERY = 3'd7;
  localparam int PHASES = 7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  cmd_t        cmd = '0;
  logic        busy;
  logic        done;
  res_t        result;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_PIECE_COUNT;
  logic [30:0] cfg_data = '0;
  int          fail_count;
  int          pending;
  int          checked;
  int          burst_left;
  int          gap;
  int          last_piece;
  int          hot_blocks;

  // per phase: piece count, piece bytes, content bytes, block indexes in use
  int phase_count [PHASES] = '{1024, 5, 1, 1024, 8, 2047, 1024};
  int phase_len [PHASES] = '{1048576, 65536, 1, 2097151, 49152, 1, 1048576};
  int phase_total [PHASES] =
    '{1073741824, 262244, 1, 2147483647, 147461, 1073741824, 1073741824};
  int phase_hot [PHASES] = '{64, 4, 1, 64, 3, 1, 8};

  block_request_tracker uut (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd), .busy(busy), .done(done),
    .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  brt_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .done(done),
    .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .checked(checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("timeout");
    $display("Some tests failed");
    $finish;
  end

  // start stays high across back-to-back transactions inside a burst
  task automatic issue(input logic [2:0] op, input int p, input int b, input int peer);
    cmd <= '{opcode: op, piece_index: 10'(p), block_index: 6'(b), peer_id: 4'(peer)};
    start <= 1'b1;
    do @(posedge clk); while (busy);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
  endtask

  task automatic configure(input int ph);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= REG_PIECE_COUNT;
    cfg_data <= 31'(phase_count[ph]);
    @(posedge clk);
    cfg_index <= REG_PIECE_BYTES;
    cfg_data <= 31'(phase_len[ph]);
    @(posedge clk);
    cfg_index <= REG_CONTENT_BYTES;
    cfg_data <= 31'(phase_total[ph]);
    @(posedge clk);
    cfg_we <= 1'b0;
    last_piece = (phase_count[ph] > MAX_PIECES) ? MAX_PIECES - 1 : phase_count[ph] - 1;
    hot_blocks = phase_hot[ph];
  endtask

  task automatic random_item();
    int          sel;
    int          p;
    int          b;
    int          peer;
    logic [2:0]  op;
    sel = $urandom_range(0, 99);
    if (sel < 30) op = OP_REQUEST;
    else if (sel < 45) op = OP_WRITING;
    else if (sel < 61) op = OP_FINISH;
    else if (sel < 74) op = OP_ABORT;
    else if (sel < 77) op = OP_CANCEL;
    else if (sel < 81) op = OP_RESTORE;
    else if (sel < 85) op = OP_HAVE;
    else op = OP_QUERY;
    sel = $urandom_range(0, 99);
    if (sel < 75) p = $urandom_range(0, 3);
    else if (sel < 85) p = last_piece;
    else p = $urandom_range(0, 1023);
    b = ($urandom_range(0, 4) != 0) ? $urandom_range(0, hot_blocks - 1) : $urandom_range(0, 63);
    peer = ($urandom_range(0, 4) < 3) ? $urandom_range(0, 3) : $urandom_range(0, 15);
    issue(op, p, b, peer);
  endtask

  initial begin
    burst_left = 8;
    last_piece = MAX_PIECES - 1;
    hot_blocks = MAX_BLOCKS;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // directed transactions at the reset geometry
    issue(OP_REQUEST, 0, 0, 0);
    issue(OP_REQUEST, 0, 0, 15);
    issue(OP_WRITING, 0, 0, 0);
    issue(OP_FINISH, 0, 0, 0);
    issue(OP_ABORT, 1, 2, 1);
    issue(OP_WRITING, 1, 2, 1);
    issue(OP_REQUEST, 1023, 63, 9);
    issue(OP_ABORT, 1023, 63, 9);
    issue(OP_REQUEST, 2, 5, 3);
    issue(OP_REQUEST, 2, 6, 3);
    issue(OP_REQUEST, 2, 6, 10);
    issue(OP_CANCEL, 0, 0, 3);
    issue(OP_QUERY, 2, 5, 0);
    issue(OP_QUERY, 2, 6, 0);
    issue(OP_HAVE, 0, 0, 0);
    issue(OP_REQUEST, 0, 1, 4);
    issue(OP_QUERY, 0, 1, 4);
    issue(OP_RESTORE, 0, 0, 0);
    issue(OP_FINISH, 3, 63, 12);
    issue(OP_QUERY, 1023, 0, 7);
    issue(OP_WRITING, 1023, 63, 5);
    issue(OP_CANCEL, 1023, 63, 15);
    for (int ph = 0; ph < PHASES; ph++) begin
      configure(ph);
      for (int i = 0; i < 133; i++) random_item();
    end
    drain();
    for (int w = 0; w < 200 && pending != 0; w++) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("checked %0d tracker results across %0d geometries, all eight opcodes",
             checked, PHASES);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+rtl/core
rtl/core/brt_pkg.sv
rtl/core/brt_geom.sv
rtl/core/block_request_tracker.sv
verif/brt_checker.sv
verif/tb_top.sv
